@@ sv/avi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avi_pkg: shared types and constants
// Sample, queue entry and result layouts plus configuration register codes
// for the accelerometer velocity integrator.
// ----------------------------------------------------------------------------
package avi_pkg;

    localparam int NUM_AXES   = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic [CFG_IDX_W-1:0]  cfg_index_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    // configuration register codes
    localparam cfg_index_t REG_BIAS_X = 3'd0;
    localparam cfg_index_t REG_BIAS_Y = 3'd1;
    localparam cfg_index_t REG_BIAS_Z = 3'd2;
    localparam cfg_index_t REG_DEAD_X = 3'd3;
    localparam cfg_index_t REG_DEAD_Y = 3'd4;
    localparam cfg_index_t REG_DEAD_Z = 3'd5;
    localparam cfg_index_t REG_WEIGHT = 3'd6;

    localparam logic [8:0] WEIGHT_RESET = 9'd205;
    localparam logic [8:0] WEIGHT_MAX   = 9'd256;

    // one raw sample request
    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic        [15:0] elapsed_ms;
    } avi_sample_t;

    // classified sample after dead band and bias
    typedef struct packed {
        logic signed [15:0] d_x;
        logic signed [15:0] d_y;
        logic signed [15:0] d_z;
        logic        [15:0] ms;
    } avi_item_t;

    // one result request
    typedef struct packed {
        logic signed [15:0] filt_out_x;
        logic signed [15:0] filt_out_y;
        logic signed [15:0] filt_out_z;
        logic signed [31:0] vel_out_x;
        logic signed [31:0] vel_out_y;
        logic signed [31:0] vel_out_z;
        logic        [31:0] speed;
    } avi_result_t;

endpackage

@@ sv/avi_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avi_front: configuration registers and sample classification
// Holds bias, dead band and weight registers; applies the dead band and
// saturating bias subtraction to each incoming sample.
// ----------------------------------------------------------------------------
module avi_front
    import avi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  cfg_index_t  cfg_index,
    input  cfg_data_t   cfg_data,
    input  avi_sample_t sample,
    output avi_item_t   item,
    output logic [8:0]  weight
);

    logic signed [15:0] bias_reg [NUM_AXES];
    logic        [14:0] dead_reg [NUM_AXES];
    logic        [8:0]  weight_reg;
    logic signed [15:0] accel [NUM_AXES];
    logic signed [15:0] d_val [NUM_AXES];

    assign cfg_ready = 1'b1;

    // register writes, unknown codes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                bias_reg[i] <= '0;
                dead_reg[i] <= '0;
            end
            weight_reg <= WEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_BIAS_X: bias_reg[0] <= cfg_data;
                REG_BIAS_Y: bias_reg[1] <= cfg_data;
                REG_BIAS_Z: bias_reg[2] <= cfg_data;
                REG_DEAD_X: dead_reg[0] <= cfg_data[14:0];
                REG_DEAD_Y: dead_reg[1] <= cfg_data[14:0];
                REG_DEAD_Z: dead_reg[2] <= cfg_data[14:0];
                REG_WEIGHT: weight_reg  <= cfg_data[8:0];
                default:    ;
            endcase
        end
    end

    // weights above one hold the filter
    assign weight = (weight_reg > WEIGHT_MAX) ? WEIGHT_MAX : weight_reg;

    assign accel[0] = sample.accel_x;
    assign accel[1] = sample.accel_y;
    assign accel[2] = sample.accel_z;

    // dead band and saturating bias subtraction per axis
    always_comb
    begin
        logic [16:0] mag;
        logic [16:0] diff;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            mag  = accel[i][15] ? (17'd0 - {accel[i][15], accel[i]})
                                : {1'b0, accel[i]};
            diff = {accel[i][15], accel[i]} - {bias_reg[i][15], bias_reg[i]};
            if (mag <= {2'b00, dead_reg[i]})
                d_val[i] = '0;
            else if (diff[16] != diff[15])
                d_val[i] = diff[16] ? 16'sh8000 : 16'sh7fff;
            else
                d_val[i] = diff[15:0];
        end
    end

    assign item.d_x = d_val[0];
    assign item.d_y = d_val[1];
    assign item.d_z = d_val[2];
    assign item.ms  = sample.elapsed_ms;

endmodule

@@ sv/avi_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avi_queue: short queue between front and back
// Holds classified samples so the input side keeps taking requests while
// the back end is busy or its result is stalled.
// ----------------------------------------------------------------------------
module avi_queue
    import avi_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  avi_item_t wr_item,
    output logic      full,
    input  logic      rd_pop,
    output logic      rd_valid,
    output avi_item_t rd_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    avi_item_t        slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full     = (count_reg == FULL_CNT);
    assign rd_valid = (count_reg != '0);
    assign do_wr    = push && !full;
    assign do_rd    = rd_pop && rd_valid;
    assign rd_item  = slot_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_item;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

@@ sv/avi_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avi_back: filter, integration and speed sequencer
// Runs the low-pass filter and trapezoid integration axis by axis on one
// shared multiplier, then a bit-serial square root, and holds the result.
// ----------------------------------------------------------------------------
module avi_back
    import avi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [8:0]  weight,
    input  logic        q_valid,
    input  avi_item_t   q_item,
    output logic        q_pop,
    output logic        empty,
    input  logic        pop,
    output avi_result_t result
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_W,
        ST_MUL_D,
        ST_FNEW,
        ST_FSUM,
        ST_MUL_T,
        ST_VEL,
        ST_SQ,
        ST_SUM,
        ST_ROOT,
        ST_DONE
    } state_t;

    state_t             state_reg;
    logic [1:0]         axis_reg;
    logic [4:0]         iter_reg;
    avi_item_t          item_reg;
    logic signed [23:0] filt_reg [NUM_AXES];
    logic signed [31:0] vel_reg  [NUM_AXES];
    logic signed [65:0] prod_reg;
    logic signed [24:0] acc_reg;
    logic signed [23:0] fnew_reg;
    logic signed [24:0] fsum_reg;
    logic        [63:0] sumsq_reg;
    logic               sq_pend_reg;
    logic        [33:0] rem_reg;
    logic        [31:0] root_reg;
    avi_result_t        result_reg;
    logic               res_valid_reg;
    logic               res_valid_next;

    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] prod_comb;
    logic signed [65:0] prod_sh8;
    logic signed [65:0] prod_sh9;
    logic signed [15:0] d_sel;
    logic signed [23:0] f_old;
    logic signed [31:0] v_old;
    logic        [9:0]  w_comp;
    logic        [25:0] fnew_sum;
    logic        [24:0] fsum_sum;
    logic        [33:0] vsum;
    logic signed [31:0] vsat;
    logic        [35:0] rem_sh;
    logic        [35:0] trial;
    logic        [35:0] rem_sub;
    logic               load_res;

    // per-axis operand selection
    always_comb
    begin
        case (axis_reg)
            2'd0:    d_sel = item_reg.d_x;
            2'd1:    d_sel = item_reg.d_y;
            default: d_sel = item_reg.d_z;
        endcase
    end

    assign f_old  = filt_reg[axis_reg];
    assign v_old  = vel_reg[axis_reg];
    assign w_comp = 10'd256 - {1'b0, weight};

    // shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MUL_W:
            begin
                mul_a = {24'd0, weight};
                mul_b = {{9{f_old[23]}}, f_old};
            end
            ST_MUL_D:
            begin
                mul_a = {23'd0, w_comp};
                mul_b = {{17{d_sel[15]}}, d_sel};
            end
            ST_MUL_T:
            begin
                mul_a = {{8{fsum_reg[24]}}, fsum_reg};
                mul_b = {17'd0, item_reg.ms};
            end
            ST_SQ:
            begin
                mul_a = {v_old[31], v_old};
                mul_b = {v_old[31], v_old};
            end
            default: ;
        endcase
    end

    assign prod_comb = mul_a * mul_b;
    assign prod_sh8  = prod_reg >>> 8;
    assign prod_sh9  = prod_reg >>> 9;

    // floor(w*f/256) + (256-w)*d, exact split of the Q8 update
    assign fnew_sum = {acc_reg[24], acc_reg} + prod_reg[25:0];
    assign fsum_sum = {fnew_reg[23], fnew_reg} + {f_old[23], f_old};

    // velocity step with 32 bit saturation
    assign vsum = {{2{v_old[31]}}, v_old} + {prod_sh9[32], prod_sh9[32:0]};
    assign vsat = (vsum[33:31] == 3'b000 || vsum[33:31] == 3'b111) ? vsum[31:0]
                : (vsum[33] ? 32'sh8000_0000 : 32'sh7fff_ffff);

    // one root bit per iteration
    assign rem_sh  = {rem_reg, sumsq_reg[63:62]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign rem_sub = rem_sh - trial;

    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign load_res = (state_reg == ST_DONE) && (!res_valid_reg || pop);

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (pop && res_valid_reg)
            res_valid_next = 1'b0;
        if (load_res)
            res_valid_next = 1'b1;
    end

    // sequencer and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= '0;
            iter_reg      <= '0;
            item_reg      <= '0;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                filt_reg[i] <= '0;
                vel_reg[i]  <= '0;
            end
            prod_reg      <= '0;
            acc_reg       <= '0;
            fnew_reg      <= '0;
            fsum_reg      <= '0;
            sumsq_reg     <= '0;
            sq_pend_reg   <= 1'b0;
            rem_reg       <= '0;
            root_reg      <= '0;
            result_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            prod_reg      <= prod_comb;
            // square of the previous axis folds in the cycle after its ST_SQ state
            if (sq_pend_reg)
            begin
                sumsq_reg   <= sumsq_reg + prod_reg[63:0];
                sq_pend_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        item_reg  <= q_item;
                        axis_reg  <= '0;
                        sumsq_reg <= '0;
                        state_reg <= ST_MUL_W;
                    end
                end
                ST_MUL_W: state_reg <= ST_MUL_D;
                ST_MUL_D:
                begin
                    acc_reg   <= prod_sh8[24:0];
                    state_reg <= ST_FNEW;
                end
                ST_FNEW:
                begin
                    fnew_reg  <= fnew_sum[23:0];
                    state_reg <= ST_FSUM;
                end
                ST_FSUM:
                begin
                    fsum_reg           <= fsum_sum;
                    filt_reg[axis_reg] <= fnew_reg;
                    state_reg          <= ST_MUL_T;
                end
                ST_MUL_T: state_reg <= ST_VEL;
                ST_VEL:
                begin
                    vel_reg[axis_reg] <= vsat;
                    state_reg         <= ST_SQ;
                end
                ST_SQ:
                begin
                    sq_pend_reg <= 1'b1;
                    if (axis_reg == 2'd2)
                        state_reg <= ST_SUM;
                    else
                    begin
                        axis_reg  <= axis_reg + 2'd1;
                        state_reg <= ST_MUL_W;
                    end
                end
                ST_SUM:
                begin
                    rem_reg   <= '0;
                    root_reg  <= '0;
                    iter_reg  <= '0;
                    state_reg <= ST_ROOT;
                end
                ST_ROOT:
                begin
                    sumsq_reg <= {sumsq_reg[61:0], 2'b00};
                    if (rem_sh >= trial)
                    begin
                        rem_reg  <= rem_sub[33:0];
                        root_reg <= {root_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= rem_sh[33:0];
                        root_reg <= {root_reg[30:0], 1'b0};
                    end
                    iter_reg <= iter_reg + 5'd1;
                    if (iter_reg == 5'd31)
                        state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (load_res)
                    begin
                        result_reg.filt_out_x <= filt_reg[0][23:8];
                        result_reg.filt_out_y <= filt_reg[1][23:8];
                        result_reg.filt_out_z <= filt_reg[2][23:8];
                        result_reg.vel_out_x  <= vel_reg[0];
                        result_reg.vel_out_y  <= vel_reg[1];
                        result_reg.vel_out_z  <= vel_reg[2];
                        result_reg.speed      <= root_reg;
                        state_reg             <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign empty  = !res_valid_reg;
    assign result = result_reg;

    // axis counter stays within the three axes
    assert property (@(posedge clk) disable iff (!rst_n) axis_reg != 2'd3)
        else $error("axis counter out of range");

    // all squares are folded in before the root starts
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROOT) |-> !sq_pend_reg)
        else $error("square pending during root");

    // a held result stalls the sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && res_valid_reg && !pop) |=> state_reg == ST_DONE)
        else $error("sequencer left done with output occupied");

    // a loaded result shows up and the sequencer returns to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        load_res |=> (res_valid_reg && state_reg == ST_IDLE))
        else $error("result load lost");

    // new items are taken only from idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !q_pop)
        else $error("queue popped while busy");

endmodule

@@ sv/accel_velocity_integrator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_velocity_integrator: three-axis acceleration to velocity
// Dead band, bias removal, Q8 low-pass filter, trapezoid integration and
// speed magnitude for one accelerometer sample per request.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on push/full; a request is taken when push is high and
//   full is low. Results leave on empty/pop; the oldest result sits on the
//   result port while empty is low and is taken when pop is high.
//   Registers are written over cfg_valid/cfg_ready (always ready) while the
//   block is idle; the user must ensure this, the block does not enforce it.
// Sequence:
//   The back end loads the sample in ST_IDLE, then for each axis runs
//   ST_MUL_W, ST_MUL_D, ST_FNEW, ST_FSUM, ST_MUL_T, ST_VEL and ST_SQ on
//   one shared 33x33 multiplier, finishes the sum of squares in ST_SUM,
//   runs the bit-serial square root in ST_ROOT and hands off the result
//   in ST_DONE. It takes a new sample only from ST_IDLE.
// Reset and stall:
//   Reset clears filter and velocity state, registers (weight to 205) and
//   the queue. While a result waits, QUEUE_DEPTH + 1 further samples are
//   still taken; after that full stays high until pop frees the output.
// ----------------------------------------------------------------------------
module accel_velocity_integrator
    import avi_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  cfg_index_t  cfg_index,
    input  cfg_data_t   cfg_data,
    input  logic        push,
    output logic        full,
    input  avi_sample_t sample,
    output logic        empty,
    input  logic        pop,
    output avi_result_t result
);

    avi_item_t  front_item;
    avi_item_t  q_item;
    logic [8:0] weight;
    logic       q_valid;
    logic       q_pop;

    // configuration and classification
    avi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample),
        .item      (front_item),
        .weight    (weight)
    );

    // decoupling queue
    avi_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_item  (front_item),
        .full     (full),
        .rd_pop   (q_pop),
        .rd_valid (q_valid),
        .rd_item  (q_item)
    );

    // filter, integration and speed
    avi_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .weight  (weight),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

@@ test/tb_accel_velocity_integrator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_accel_velocity_integrator: self-checking bench for the velocity integrator
// Drives accelerometer samples through the push/full queue, predicts every
// result with an independent fixed-point model of the dead band, bias, Q8
// low-pass filter, trapezoid integration and speed root, and checks each
// popped result field by field. Covers register extremes, saturation,
// filter hold, random traffic with random gaps on both sides and a long
// output stall that backs up the input.
// ----------------------------------------------------------------------------
module tb_accel_velocity_integrator;
    import avi_pkg::*;

    // clock, reset and block ports
    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    cfg_index_t  cfg_index;
    cfg_data_t   cfg_data;
    logic        push;
    logic        full;
    avi_sample_t sample;
    logic        empty;
    logic        pop;
    avi_result_t result;

    // predictor registers and state
    longint     bias_reg [3];
    longint     dead_reg [3];
    logic [8:0] weight_reg;
    longint     filt_q8 [3];
    longint     vel_acc [3];

    avi_result_t expected_results [$];

    // traffic shaping
    bit tx_idle_on;
    bit rx_idle_on;
    int rx_hold_req;

    // run statistics
    int samples_sent;
    int results_checked;
    int reg_writes;
    int stalled_offers;
    int mismatches;

    accel_velocity_integrator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .sample    (sample),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

    // 50 MHz clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // offers refused because the input queue is full
    always @(posedge clk)
    begin
        if (rst_n && push && full)
            stalled_offers++;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    function automatic longint clamp_range(input longint v, input longint lo,
                                           input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // floor square root, one result bit per step from the top
    function automatic logic [31:0] root_floor(input logic [63:0] n);
        logic [31:0] root;
        logic [31:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (32'd1 << b);
            if (64'(trial) * 64'(trial) <= n)
                root = trial;
        end
        return root;
    endfunction

    function automatic void apply_register(input cfg_index_t idx, input cfg_data_t data);
        case (idx)
            REG_BIAS_X: bias_reg[0] = longint'($signed(data));
            REG_BIAS_Y: bias_reg[1] = longint'($signed(data));
            REG_BIAS_Z: bias_reg[2] = longint'($signed(data));
            REG_DEAD_X: dead_reg[0] = longint'(data[14:0]);
            REG_DEAD_Y: dead_reg[1] = longint'(data[14:0]);
            REG_DEAD_Z: dead_reg[2] = longint'(data[14:0]);
            REG_WEIGHT: weight_reg  = data[8:0];
            default: ;
        endcase
    endfunction

    // advance filter and velocity for one sample, return the expected result
    function automatic avi_result_t integrate_sample(input avi_sample_t s);
        longint      raw [3];
        longint      filt_int [3];
        longint      w;
        longint      ms;
        longint      mag;
        longint      d;
        longint      f_prev;
        longint      dv;
        logic [63:0] mag_v;
        logic [63:0] energy;
        avi_result_t r;
        w      = (weight_reg > WEIGHT_MAX) ? longint'(WEIGHT_MAX) : longint'(weight_reg);
        ms     = longint'(s.elapsed_ms);
        raw[0] = longint'(s.accel_x);
        raw[1] = longint'(s.accel_y);
        raw[2] = longint'(s.accel_z);
        energy = '0;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            mag = (raw[i] < 0) ? -raw[i] : raw[i];
            d   = 0;
            if (mag > dead_reg[i])
                d = clamp_range(raw[i] - bias_reg[i], -32768, 32767);
            f_prev      = filt_q8[i];
            filt_q8[i]  = (w * f_prev + (256 - w) * d * 256) >>> 8;
            dv          = ((filt_q8[i] + f_prev) * ms) >>> 9;
            vel_acc[i]  = clamp_range(vel_acc[i] + dv, -64'sd2147483648, 64'sd2147483647);
            filt_int[i] = filt_q8[i] >>> 8;
            mag_v       = 64'((vel_acc[i] < 0) ? -vel_acc[i] : vel_acc[i]);
            energy      = energy + mag_v * mag_v;
        end
        r.filt_out_x = 16'(filt_int[0]);
        r.filt_out_y = 16'(filt_int[1]);
        r.filt_out_z = 16'(filt_int[2]);
        r.vel_out_x  = 32'(vel_acc[0]);
        r.vel_out_y  = 32'(vel_acc[1]);
        r.vel_out_z  = 32'(vel_acc[2]);
        r.speed      = root_floor(energy);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // drivers and checker
    // ------------------------------------------------------------------------

    function automatic avi_sample_t make_sample(input int x, input int y, input int z,
                                                input int ms);
        avi_sample_t s;
        s.accel_x    = 16'(x);
        s.accel_y    = 16'(y);
        s.accel_z    = 16'(z);
        s.elapsed_ms = 16'(ms);
        return s;
    endfunction

    // one sample request; push stays high when the next one follows at once
    task automatic send_sample(input avi_sample_t s);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push   <= 1'b1;
        sample <= s;
        do
            @(posedge clk);
        while (full);
        expected_results.push_back(integrate_sample(s));
        samples_sent++;
    endtask

    // all seven registers back to back, valid held high through the burst
    task automatic write_settings(input int bx, input int by, input int bz,
                                  input int dx, input int dy, input int dz,
                                  input int wt);
        cfg_index_t regs [7];
        cfg_data_t  vals [7];
        regs = '{REG_BIAS_X, REG_BIAS_Y, REG_BIAS_Z, REG_DEAD_X, REG_DEAD_Y,
                 REG_DEAD_Z, REG_WEIGHT};
        vals = '{16'(bx), 16'(by), 16'(bz), 16'(dx), 16'(dy), 16'(dz), 16'(wt)};
        cfg_valid <= 1'b1;
        for (int i = 0; i < 7; i++)
        begin
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            apply_register(regs[i], vals[i]);
            reg_writes++;
        end
        cfg_valid <= 1'b0;
    endtask

    // stop offering and let every expected result come out
    task automatic wait_idle();
        push <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch at result %0d, %s: expected 'h%08h, got 'h%08h",
                         results_checked, name, want, got);
        end
    endtask

    task automatic check_result(input avi_result_t got);
        avi_result_t want;
        if (expected_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result %0d with no sample pending", results_checked);
        end
        else
        begin
            want = expected_results.pop_front();
            compare_field("filt_out_x", 32'(want.filt_out_x), 32'(got.filt_out_x));
            compare_field("filt_out_y", 32'(want.filt_out_y), 32'(got.filt_out_y));
            compare_field("filt_out_z", 32'(want.filt_out_z), 32'(got.filt_out_z));
            compare_field("vel_out_x", want.vel_out_x, got.vel_out_x);
            compare_field("vel_out_y", want.vel_out_y, got.vel_out_y);
            compare_field("vel_out_z", want.vel_out_z, got.vel_out_z);
            compare_field("speed", want.speed, got.speed);
        end
        results_checked++;
    endtask

    // result side: random pop gaps plus an optional long hold
    initial
    begin : result_drain
        int          gap;
        avi_result_t got;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = rx_idle_on ? $urandom_range(0, 9) : 0;
            if (rx_hold_req > 0)
            begin
                gap         = gap + rx_hold_req;
                rx_hold_req = 0;
            end
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do
                @(posedge clk);
            while (empty);
            got = result;
            check_result(got);
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------

    function automatic logic signed [15:0] random_accel(input longint band);
        longint sgn;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 3))
                    0:       return 16'sh7FFF;
                    1:       return 16'sh8000;
                    2:       return 16'sh0000;
                    default: return 16'shFFFF;
                endcase
            end
            1, 2:
            begin
                sgn = ($urandom_range(0, 1) != 0) ? -1 : 1;
                return 16'(sgn * (band + longint'($urandom_range(0, 2)) - 1));
            end
            3, 4, 5: return 16'(longint'($urandom_range(0, 1000)) - 500);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic avi_sample_t random_sample();
        avi_sample_t s;
        s.accel_x = random_accel(dead_reg[0]);
        s.accel_y = random_accel(dead_reg[1]);
        s.accel_z = random_accel(dead_reg[2]);
        case ($urandom_range(0, 9))
            0:       s.elapsed_ms = 16'd0;
            1:       s.elapsed_ms = 16'hFFFF;
            2:       s.elapsed_ms = 16'($urandom);
            default: s.elapsed_ms = 16'($urandom_range(0, 40));
        endcase
        return s;
    endfunction

    function automatic int random_bias();
        case ($urandom_range(0, 7))
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            3:       return int'($signed(16'($urandom)));
            default: return int'($urandom_range(0, 4000)) - 2000;
        endcase
    endfunction

    function automatic int random_dead();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 32767;
            2:       return int'($urandom_range(0, 32767));
            default: return int'($urandom_range(0, 3000));
        endcase
    endfunction

    function automatic int random_weight();
        case ($urandom_range(0, 11))
            0:       return 0;
            1:       return 1;
            2:       return 128;
            3:       return 205;
            4:       return 255;
            5:       return 256;
            6:       return 300;
            7:       return 511;
            default: return int'($urandom_range(0, 256));
        endcase
    endfunction

    // reset register values, extremes of every field, zero elapsed time
    task automatic test_default_settings();
        send_sample(make_sample(0, 0, 0, 0));
        send_sample(make_sample(32767, 32767, 32767, 10));
        send_sample(make_sample(-32768, -32768, -32768, 10));
        send_sample(make_sample(-1, 1, 0, 65535));
        send_sample(make_sample(100, -100, 5, 0));
        send_sample(make_sample(32767, -32768, 1, 65535));
    endtask

    // bias subtraction saturating both ways, dead band edges
    task automatic test_dead_band_and_bias();
        wait_idle();
        write_settings(-32768, 32767, 1, 0, 0, 32767, 0);
        send_sample(make_sample(32767, -32768, 32767, 100));
        send_sample(make_sample(-32768, 32767, -32768, 100));
        send_sample(make_sample(100, -100, 32767, 1));
        send_sample(make_sample(1, -1, -32768, 0));
        wait_idle();
        write_settings(5, -5, 0, 100, 100, 100, 128);
        send_sample(make_sample(100, 101, -100, 20));
        send_sample(make_sample(-101, -100, 101, 20));
        send_sample(make_sample(0, 1, -1, 20));
    endtask

    // velocity saturation at both limits, filter hold at and above full weight
    task automatic test_saturation_and_hold();
        wait_idle();
        write_settings(0, 0, 0, 0, 0, 0, 0);
        repeat (2) send_sample(make_sample(32767, 32767, -32768, 65535));
        repeat (3) send_sample(make_sample(-32768, -32768, 32767, 65535));
        wait_idle();
        write_settings(0, 0, 0, 0, 0, 0, 256);
        send_sample(make_sample(1000, -1000, 0, 10));
        send_sample(make_sample(32767, 0, -32768, 65535));
        wait_idle();
        write_settings(0, 0, 0, 0, 0, 0, 511);
        send_sample(make_sample(-500, 500, 32767, 30));
    endtask

    // random settings per phase, idling patterns rotate between phases
    task automatic test_random_traffic(input int phases, input int per_phase);
        for (int p = 0; p < phases; p++)
        begin
            wait_idle();
            write_settings(random_bias(), random_bias(), random_bias(),
                           random_dead(), random_dead(), random_dead(), random_weight());
            tx_idle_on = (p % 4) < 2;
            rx_idle_on = (p % 2) == 0;
            repeat (per_phase) send_sample(random_sample());
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // long output hold while the sender keeps offering
    task automatic test_output_stall();
        wait_idle();
        write_settings(random_bias(), random_bias(), random_bias(), 50, 50, 50, 205);
        tx_idle_on  = 1'b0;
        rx_hold_req = 600;
        repeat (40) send_sample(random_sample());
        tx_idle_on  = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_sequence
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_BIAS_X;
        cfg_data  <= '0;
        push      <= 1'b0;
        sample    <= '0;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            bias_reg[i] = 0;
            dead_reg[i] = 0;
            filt_q8[i]  = 0;
            vel_acc[i]  = 0;
        end
        weight_reg  = WEIGHT_RESET;
        tx_idle_on  = 1'b1;
        rx_idle_on  = 1'b1;
        rx_hold_req = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_settings();
        test_dead_band_and_bias();
        test_saturation_and_hold();
        test_random_traffic(8, 200);
        test_output_stall();

        // drain and let the block settle
        push <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);

        $display("run covered %0d samples and %0d results over %0d register writes",
                 samples_sent, results_checked, reg_writes);
        $display("input refused %0d offers while full, %0d field mismatches",
                 stalled_offers, mismatches);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // watchdog
    initial
    begin : watchdog
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

@@ accel_velocity_integrator.f @@
sv/avi_pkg.sv
sv/avi_front.sv
sv/avi_queue.sv
sv/avi_back.sv
sv/accel_velocity_integrator.sv
test/tb_accel_velocity_integrator.sv
